// ===== rtl/mi4_pkg.sv =====
// Shared types, constants and schedule tables for the 4x4 matrix inverse unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mi4_pkg;

	localparam int ELEM_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DIGIT_W        = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int NUM_ELEMS      = 16;
	localparam int NUM_MINORS     = 12;
	localparam int MINOR_BASE     = NUM_ELEMS;
	localparam int ADDR_W         = $clog2(NUM_ELEMS + NUM_MINORS);

	// Group numbers of the compute schedule: twelve minors, the determinant,
	// then one group per adjugate entry.
	localparam logic [4:0] GRP_DET      = 5'd12;
	localparam logic [4:0] GRP_ADJ0     = 5'd13;
	localparam logic [4:0] GRP_ADJ_LAST = 5'd28;

	typedef struct packed {
		logic [3:0] idx;
		logic       last;
	} elem_tag_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic              neg;
		logic              grp_end;
	} term_t;

	// Each minor is x[p]*x[q] - x[r]*x[s].
	localparam int MINOR_TAB [12][4] = '{
		'{0, 5, 1, 4}, '{0, 6, 2, 4}, '{0, 7, 3, 4}, '{1, 6, 2, 5},
		'{1, 7, 3, 5}, '{2, 7, 3, 6}, '{8, 13, 9, 12}, '{8, 14, 10, 12},
		'{8, 15, 11, 12}, '{9, 14, 10, 13}, '{9, 15, 11, 13}, '{10, 15, 11, 14}
	};

	// Adjugate entry: three terms of {element, minor number, negate}.
	localparam int ADJ_TAB [16][3][3] = '{
		'{'{5, 11, 0}, '{6, 10, 1}, '{7, 9, 0}},
		'{'{1, 11, 1}, '{2, 10, 0}, '{3, 9, 1}},
		'{'{13, 5, 0}, '{14, 4, 1}, '{15, 3, 0}},
		'{'{9, 5, 1}, '{10, 4, 0}, '{11, 3, 1}},
		'{'{4, 11, 1}, '{6, 8, 0}, '{7, 7, 1}},
		'{'{0, 11, 0}, '{2, 8, 1}, '{3, 7, 0}},
		'{'{12, 5, 1}, '{14, 2, 0}, '{15, 1, 1}},
		'{'{8, 5, 0}, '{10, 2, 1}, '{11, 1, 0}},
		'{'{4, 10, 0}, '{5, 8, 1}, '{7, 6, 0}},
		'{'{0, 10, 1}, '{1, 8, 0}, '{3, 6, 1}},
		'{'{12, 4, 0}, '{13, 2, 1}, '{15, 0, 0}},
		'{'{8, 4, 1}, '{9, 2, 0}, '{11, 0, 1}},
		'{'{4, 9, 1}, '{5, 7, 0}, '{6, 6, 1}},
		'{'{0, 9, 0}, '{1, 7, 1}, '{2, 6, 0}},
		'{'{12, 3, 1}, '{13, 1, 0}, '{14, 0, 1}},
		'{'{8, 3, 0}, '{9, 1, 1}, '{10, 0, 0}}
	};

	// Operand addresses and sign of one product term of the schedule.
	function automatic term_t term_lookup(input logic [4:0] grp, input logic [2:0] sub);
		term_t      t;
		logic [3:0] k;
		t = '0;
		k = '0;
		if (grp < GRP_DET) begin
			k = grp[3:0];
			if (sub[0] == 1'b0) begin
				t.addr_a = ADDR_W'(MINOR_TAB[k][0]);
				t.addr_b = ADDR_W'(MINOR_TAB[k][1]);
				t.neg    = 1'b0;
				t.grp_end = 1'b0;
			end else begin
				t.addr_a = ADDR_W'(MINOR_TAB[k][2]);
				t.addr_b = ADDR_W'(MINOR_TAB[k][3]);
				t.neg    = 1'b1;
				t.grp_end = 1'b1;
			end
		end else if (grp == GRP_DET) begin
			t.addr_a  = ADDR_W'(MINOR_BASE + int'(sub));
			t.addr_b  = ADDR_W'(MINOR_BASE + NUM_MINORS - 1 - int'(sub));
			t.neg     = (sub == 3'd1) || (sub == 3'd4);
			t.grp_end = (sub == 3'd5);
		end else begin
			k = 4'(grp - GRP_ADJ0);
			t.addr_a  = ADDR_W'(ADJ_TAB[k][sub[1:0]][0]);
			t.addr_b  = ADDR_W'(MINOR_BASE + ADJ_TAB[k][sub[1:0]][1]);
			t.neg     = (ADJ_TAB[k][sub[1:0]][2] != 0);
			t.grp_end = (sub == 3'd2);
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mi4_front.sv =====
// Input side of the matrix inverse unit: takes element beats and tags each
// with its storage index and an end-of-matrix mark. Uses mi4_pkg.
`default_nettype none

module mi4_front #(
	parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  element_valid,
	output      logic                  element_ready,
	input  wire logic [ELEM_WIDTH-1:0] element_value,
	input  wire logic                  queue_full,
	output      logic                  push,
	output      logic [ELEM_WIDTH-1:0] push_value,
	output      mi4_pkg::elem_tag_t    push_tag
);
	import mi4_pkg::*;

	logic [3:0] load_count_q;

	assign element_ready = !queue_full;
	assign push          = element_valid && !queue_full;
	assign push_value    = element_value;
	assign push_tag.idx  = load_count_q;
	assign push_tag.last = (load_count_q == 4'(NUM_ELEMS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (push) begin
			load_count_q <= load_count_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mi4_queue.sv =====
// Small first-in first-out queue between the input side and the compute engine.
// Generic width; depth from mi4_pkg.
`default_nettype none

module mi4_queue #(
	parameter int WIDTH = 37,
	parameter int DEPTH = mi4_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] pop_data,
	output      logic             not_empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mi4_divider.sv =====
// Radix-2 restoring divider that forms adj * 2^(2*FRAC_BITS) / det, truncated
// toward zero and saturated to ELEM_WIDTH signed bits. Uses mi4_pkg.
`default_nettype none

module mi4_divider #(
	parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF,
	parameter int ACC_W      = 4 * ELEM_WIDTH + 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [ACC_W-1:0] num_in,
	input  wire logic signed [ACC_W-1:0] den_in,
	output      logic                    done,
	output      logic [ELEM_WIDTH-1:0]   quot
);
	import mi4_pkg::*;

	localparam int NW    = ACC_W + 2 * FRAC_BITS;
	localparam int CW    = ACC_W + ELEM_WIDTH + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(ELEM_WIDTH);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_PREP = 4'b0010,
		D_ITER = 4'b0100,
		D_FIN  = 4'b1000
	} div_state_t;

	div_state_t             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [ACC_W-1:0]       nmag_q, dmag_q, rem_q;
	logic [ELEM_WIDTH-1:0]  low_q, q_q, quot_q;
	logic                   neg_q, ovf_q;
	logic [NW-1:0]          num_sh;
	logic [CW-1:0]          num_ext, den_ext, rem_init;
	logic [ACC_W:0]         rem2, rem2_sub;
	logic                   rem_ge;
	logic [ELEM_WIDTH-1:0]  lim, mag;

	assign num_sh   = {nmag_q, {(2 * FRAC_BITS){1'b0}}};
	assign num_ext  = CW'(num_sh);
	assign den_ext  = {{(CW - ACC_W - ELEM_WIDTH){1'b0}}, dmag_q, {ELEM_WIDTH{1'b0}}};
	assign rem_init = num_ext >> ELEM_WIDTH;
	assign rem2     = {rem_q, low_q[ELEM_WIDTH-1]};
	assign rem_ge   = (rem2 >= {1'b0, dmag_q});
	assign rem2_sub = rem2 - {1'b0, dmag_q};
	assign lim      = neg_q ? {1'b1, {(ELEM_WIDTH - 1){1'b0}}}
	                        : {1'b0, {(ELEM_WIDTH - 1){1'b1}}};
	assign mag      = (ovf_q || (q_q > lim)) ? lim : q_q;
	assign done     = (state_q == D_FIN);
	assign quot     = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (start) state_q <= D_PREP;
				end
				D_PREP: begin
					state_q <= D_ITER;
					cnt_q   <= CNT_W'(ELEM_WIDTH - 1);
				end
				D_ITER: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) state_q <= D_FIN;
				end
				D_FIN: begin
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			nmag_q <= num_in[ACC_W-1] ? ACC_W'(-num_in) : ACC_W'(num_in);
			dmag_q <= den_in[ACC_W-1] ? ACC_W'(-den_in) : ACC_W'(den_in);
			neg_q  <= num_in[ACC_W-1] != den_in[ACC_W-1];
		end
		if (state_q == D_PREP) begin
			ovf_q <= (num_ext >= den_ext);
			rem_q <= rem_init[ACC_W-1:0];
			low_q <= num_sh[ELEM_WIDTH-1:0];
			q_q   <= '0;
		end
		if (state_q == D_ITER) begin
			rem_q <= rem_ge ? rem2_sub[ACC_W-1:0] : rem2[ACC_W-1:0];
			q_q   <= {q_q[ELEM_WIDTH-2:0], rem_ge};
			low_q <= low_q << 1;
		end
		if (state_q == D_FIN) begin
			quot_q <= neg_q ? (~mag + ELEM_WIDTH'(1)) : mag;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mi4_engine.sv =====
// Compute engine of the matrix inverse unit: stores a matrix, forms minors,
// determinant and adjugate on one shared multiplier, divides, and registers
// each result. Uses mi4_pkg and mi4_divider.
`default_nettype none

module mi4_engine #(
	parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire logic [ELEM_WIDTH-1:0] q_value,
	input  wire mi4_pkg::elem_tag_t    q_tag,
	output      logic                  q_pop,
	output      logic                  result_valid,
	input  wire logic                  result_ready,
	output      logic [ELEM_WIDTH-1:0] result_value,
	output      logic [3:0]            result_index,
	output      logic                  singular,
	output      logic                  last
);
	import mi4_pkg::*;

	localparam int MW        = 2 * ELEM_WIDTH + 1;
	localparam int ND        = (MW + DIGIT_W - 1) / DIGIT_W;
	localparam int YW        = ND * DIGIT_W;
	localparam int PW        = MW + YW;
	localparam int ACC_W     = 4 * ELEM_WIDTH + 5;
	localparam int DCW       = $clog2(ND);
	localparam int MEM_DEPTH = NUM_ELEMS + NUM_MINORS;

	typedef enum logic [9:0] {
		S_LOAD  = 10'b0000000001,
		S_RDA   = 10'b0000000010,
		S_RDB   = 10'b0000000100,
		S_CAP   = 10'b0000001000,
		S_MUL   = 10'b0000010000,
		S_FLUSH = 10'b0000100000,
		S_ADD   = 10'b0001000000,
		S_END   = 10'b0010000000,
		S_DIV   = 10'b0100000000,
		S_EMIT  = 10'b1000000000
	} eng_state_t;

	eng_state_t               state_q;
	logic [4:0]               grp_q;
	logic [2:0]               sub_q;
	logic [DCW-1:0]           dig_q;
	logic                     sing_q;
	logic                     out_valid_q;
	logic [ELEM_WIDTH-1:0]    out_value_q;
	logic [3:0]               out_index_q;
	logic                     out_sing_q, out_last_q;

	logic [MW-1:0]            vmem [MEM_DEPTH];
	logic [MW-1:0]            rd_q;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
	logic [MW-1:0]            mem_wdata;

	logic [MW-1:0]            opx_q;
	logic                     sx_q, neg_q;
	logic [YW-1:0]            opy_q;
	logic [MW+DIGIT_W-1:0]    pp_s1;
	logic [PW-1:0]            prod_q;
	logic signed [ACC_W-1:0]  acc_q, det_q;

	term_t                    term;
	logic                     rd_neg;
	logic [MW-1:0]            rd_mag;
	logic [MW+DIGIT_W-1:0]    pp_next;
	logic                     emit_go, div_start, div_done;
	logic [ELEM_WIDTH-1:0]    div_quot;

	assign term    = term_lookup(grp_q, sub_q);
	assign rd_neg  = rd_q[MW-1];
	assign rd_mag  = rd_neg ? (~rd_q + MW'(1)) : rd_q;
	assign pp_next = {{DIGIT_W{1'b0}}, opx_q} * {{MW{1'b0}}, opy_q[YW-1 -: DIGIT_W]};
	assign q_pop   = (state_q == S_LOAD) && q_valid;
	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || result_ready);
	assign div_start = (state_q == S_END) && (grp_q > GRP_DET);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = (state_q == S_RDB) ? term.addr_b : term.addr_a;
		if (q_pop) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(q_tag.idx);
			mem_wdata = {{(MW - ELEM_WIDTH){q_value[ELEM_WIDTH-1]}}, q_value};
		end else if ((state_q == S_END) && (grp_q < GRP_DET)) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(MINOR_BASE) + ADDR_W'(grp_q);
			mem_wdata = acc_q[MW-1:0];
		end
	end

	// Operand store: elements at 0..15, minors at 16..27.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[mem_waddr] <= mem_wdata;
		end
		rd_q <= vmem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			grp_q       <= '0;
			sub_q       <= '0;
			dig_q       <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (q_valid && q_tag.last) begin
						state_q <= S_RDA;
						grp_q   <= '0;
						sub_q   <= '0;
						sing_q  <= 1'b0;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_CAP;
				S_CAP: begin
					state_q <= S_MUL;
					dig_q   <= '0;
				end
				S_MUL: begin
					dig_q <= dig_q + DCW'(1);
					if (dig_q == DCW'(ND - 1)) state_q <= S_FLUSH;
				end
				S_FLUSH: state_q <= S_ADD;
				S_ADD: begin
					if (term.grp_end) begin
						state_q <= S_END;
					end else begin
						sub_q   <= sub_q + 3'd1;
						state_q <= S_RDA;
					end
				end
				S_END: begin
					sub_q <= '0;
					if (grp_q < GRP_DET) begin
						grp_q   <= grp_q + 5'd1;
						state_q <= S_RDA;
					end else if (grp_q == GRP_DET) begin
						grp_q <= GRP_ADJ0;
						if (acc_q == '0) begin
							sing_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_RDA;
						end
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						if (grp_q == GRP_ADJ_LAST) begin
							state_q <= S_LOAD;
						end else begin
							grp_q   <= grp_q + 5'd1;
							state_q <= sing_q ? S_EMIT : S_RDA;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			acc_q <= '0;
		end
		if (state_q == S_RDB) begin
			opx_q <= rd_mag;
			sx_q  <= rd_neg;
		end
		if (state_q == S_CAP) begin
			opy_q  <= YW'(rd_mag);
			neg_q  <= sx_q ^ rd_neg ^ term.neg;
			prod_q <= '0;
		end
		if (state_q == S_MUL) begin
			pp_s1 <= pp_next;
			opy_q <= opy_q << DIGIT_W;
			if (dig_q != '0) begin
				prod_q <= (prod_q << DIGIT_W) + PW'(pp_s1);
			end
		end
		if (state_q == S_FLUSH) begin
			prod_q <= (prod_q << DIGIT_W) + PW'(pp_s1);
		end
		if (state_q == S_ADD) begin
			acc_q <= neg_q ? (acc_q - ACC_W'(prod_q)) : (acc_q + ACC_W'(prod_q));
		end
		if (state_q == S_END) begin
			acc_q <= '0;
			if (grp_q == GRP_DET) begin
				det_q <= acc_q;
			end
		end
		if (emit_go) begin
			out_value_q <= sing_q ? '0 : div_quot;
			out_index_q <= 4'(grp_q - GRP_ADJ0);
			out_sing_q  <= sing_q;
			out_last_q  <= (grp_q == GRP_ADJ_LAST);
		end
	end

	mi4_divider #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.ACC_W      (ACC_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_in (acc_q),
		.den_in (det_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign result_valid = out_valid_q;
	assign result_value = out_value_q;
	assign result_index = out_index_q;
	assign singular     = out_sing_q;
	assign last         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/matrix4_inverse_unit.sv =====
// Top level of the 4x4 matrix inverse unit in signed fixed point.
// Depends on mi4_pkg, mi4_front, mi4_queue, mi4_engine and mi4_divider.
//
// The unit takes the sixteen elements of a 4x4 matrix as element beats in
// storage order 0 to 15, each signed with FRAC_BITS fraction bits (Q16.16 by
// default), and answers with sixteen result beats in storage order holding
// the inverse, adj * 2^(2*FRAC_BITS) / det truncated toward zero and
// saturated to ELEM_WIDTH signed bits; result_index names the element and
// last marks the sixteenth beat. A matrix whose determinant is exactly zero
// yields sixteen zero results with singular set. All intermediate values
// (minors, determinant, adjugate) are exact. Timing: element beats are taken
// one per cycle into a small queue while it has room, so up to four elements
// of the next matrix are accepted while the engine is busy. Once a matrix is
// complete the engine works through, with ND = ceil((2*ELEM_WIDTH+1)/16)
// digit steps of its one shared multiplier, 78 product terms, 29 group
// closings and 16 divisions, each division followed by one result emit. The
// multiplier digit loop and the bit-per-cycle divider set its time per
// matrix. A singular matrix skips the adjugate and emits its sixteen zero
// results.
`default_nettype none

module matrix4_inverse_unit #(
	parameter int ELEM_WIDTH = mi4_pkg::ELEM_WIDTH_DEF,
	parameter int FRAC_BITS  = mi4_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  element_valid,
	output      logic                  element_ready,
	input  wire logic [ELEM_WIDTH-1:0] element_value,
	output      logic                  result_valid,
	input  wire logic                  result_ready,
	output      logic [ELEM_WIDTH-1:0] result_value,
	output      logic [3:0]            result_index,
	output      logic                  singular,
	output      logic                  last
);
	import mi4_pkg::*;

	localparam int QW = ELEM_WIDTH + $bits(elem_tag_t);

	// Front side: beat counting and tagging.
	logic                  push, queue_full, pop, queue_nempty;
	logic [ELEM_WIDTH-1:0] push_value, pop_value;
	elem_tag_t             push_tag, pop_tag;
	logic [QW-1:0]         pop_data;

	mi4_front #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_valid (element_valid),
		.element_ready (element_ready),
		.element_value (element_value),
		.queue_full    (queue_full),
		.push          (push),
		.push_value    (push_value),
		.push_tag      (push_tag)
	);

	// The queue decouples the input handshake from the engine, which only
	// drains it while it is loading a matrix.
	mi4_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_value}),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (queue_nempty)
	);

	assign pop_tag   = pop_data[QW-1:ELEM_WIDTH];
	assign pop_value = pop_data[ELEM_WIDTH-1:0];

	// Back side: the engine holds its results in an output register, so it
	// stalls only when a finished result is still waiting to be taken.
	mi4_engine #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (queue_nempty),
		.q_value      (pop_value),
		.q_tag        (pop_tag),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_value (result_value),
		.result_index (result_index),
		.singular     (singular),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== rtl/mi4_checker.sv =====
// Port-level checks for the matrix inverse unit, attached to the top level
// by the bind statement at the end of this file. Uses no package.
`default_nettype none

module mi4_checker #(
	parameter int ELEM_WIDTH = 32
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  element_valid,
	input wire logic                  element_ready,
	input wire logic [ELEM_WIDTH-1:0] element_value,
	input wire logic                  result_valid,
	input wire logic                  result_ready,
	input wire logic [ELEM_WIDTH-1:0] result_value,
	input wire logic [3:0]            result_index,
	input wire logic                  singular,
	input wire logic                  last
);

	// A stalled element beat stays offered with its value unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		element_valid && !element_ready |=> element_valid && $stable(element_value))
		else $error("element beat changed while stalled");

	// A stalled result beat stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_value) && $stable(result_index))
		else $error("result beat changed while stalled");

	// The end-of-matrix mark sits on index fifteen and nowhere else.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == (result_index == 4'd15)))
		else $error("last does not match result index");

	// A singular matrix produces only zero results.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && singular |-> (result_value == '0))
		else $error("nonzero result for singular matrix");

endmodule

bind matrix4_inverse_unit mi4_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi4_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for matrix4_inverse_unit: element beats in, inverse beats out.
// Depends on mi4_pkg and the RTL of the unit; the expected inverse comes from a local model.
`timescale 1ns / 1ps

module tb;

	import mi4_pkg::*;

	localparam int EW = ELEM_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;

	// How the expected beats of one matrix are obtained.
	localparam int MK_MODEL = 0;
	localparam int MK_ZERO  = 1;
	localparam int MK_IDENT = 2;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [EW-1:0] value;
		logic [3:0]    index;
		logic          sing;
		logic          last;
	} inv_beat_t;

	typedef struct {
		logic [EW-1:0] value;
		int            kind;
	} stim_row_t;

	logic          clk;
	logic          arst_n;
	logic          element_valid;
	logic          element_ready;
	logic [EW-1:0] element_value;
	logic          result_valid;
	logic          result_ready;
	logic [EW-1:0] result_value;
	logic [3:0]    result_index;
	logic          singular;
	logic          last;

	matrix4_inverse_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_valid (element_valid),
		.element_ready (element_ready),
		.element_value (element_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_value  (result_value),
		.result_index  (result_index),
		.singular      (singular),
		.last          (last)
	);

	// Directed matrices: all zeros (singular), identity in Q16.16, and a mix of
	// the most negative, most positive and small values that drives saturation.
	localparam logic [EW-1:0] ONE_Q = 32'h0001_0000;
	localparam logic [EW-1:0] MAX_E = 32'h7FFF_FFFF;
	localparam logic [EW-1:0] MIN_E = 32'h8000_0000;
	stim_row_t directed_rows [48] = '{
		'{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO},
		'{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO},
		'{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO},
		'{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO}, '{32'd0, MK_ZERO},
		'{ONE_Q, MK_IDENT}, '{32'd0, MK_IDENT}, '{32'd0, MK_IDENT}, '{32'd0, MK_IDENT},
		'{32'd0, MK_IDENT}, '{ONE_Q, MK_IDENT}, '{32'd0, MK_IDENT}, '{32'd0, MK_IDENT},
		'{32'd0, MK_IDENT}, '{32'd0, MK_IDENT}, '{ONE_Q, MK_IDENT}, '{32'd0, MK_IDENT},
		'{32'd0, MK_IDENT}, '{32'd0, MK_IDENT}, '{32'd0, MK_IDENT}, '{ONE_Q, MK_IDENT},
		'{MIN_E, MK_MODEL}, '{MAX_E, MK_MODEL}, '{32'd1, MK_MODEL}, '{32'd0, MK_MODEL},
		'{MAX_E, MK_MODEL}, '{MIN_E, MK_MODEL}, '{32'hFFFF_FFFF, MK_MODEL}, '{32'd1, MK_MODEL},
		'{32'd1, MK_MODEL}, '{32'd0, MK_MODEL}, '{MIN_E, MK_MODEL}, '{32'd2, MK_MODEL},
		'{32'd0, MK_MODEL}, '{32'd1, MK_MODEL}, '{32'd3, MK_MODEL}, '{MAX_E, MK_MODEL}
	};

	stim_row_t     stim_q[$];
	inv_beat_t     inverse_q[$];
	logic [EW-1:0] matrix_buf [16];
	int            load_pos;
	int            sent;
	int            send_gap;
	int            recv_gap;
	int            quiet_from;
	int            mismatches;
	bit            stim_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic wide_t wabs(input wide_t v);
		return (v < 0) ? -v : v;
	endfunction

	// Exact inverse of the buffered matrix: minors, determinant and adjugate at
	// full width, then adj * 2^(2*FB) / det truncated toward zero and saturated.
	function automatic void predict_inverse();
		wide_t     x [16];
		wide_t     m [12];
		wide_t     det, adj, q, lim;
		bit        neg;
		inv_beat_t b;
		for (int k = 0; k < 16; k++) x[k] = wide_t'($signed(matrix_buf[k]));
		for (int k = 0; k < 12; k++)
			m[k] = x[MINOR_TAB[k][0]] * x[MINOR_TAB[k][1]]
				- x[MINOR_TAB[k][2]] * x[MINOR_TAB[k][3]];
		det = 0;
		for (int k = 0; k < 6; k++)
			if (k == 1 || k == 4) det = det - m[k] * m[11 - k];
			else det = det + m[k] * m[11 - k];
		for (int k = 0; k < 16; k++) begin
			b.index = 4'(k);
			b.last  = (k == 15);
			b.sing  = (det == 0);
			b.value = '0;
			if (det != 0) begin
				adj = 0;
				for (int j = 0; j < 3; j++)
					if (ADJ_TAB[k][j][2] != 0)
						adj = adj - x[ADJ_TAB[k][j][0]] * m[ADJ_TAB[k][j][1]];
					else
						adj = adj + x[ADJ_TAB[k][j][0]] * m[ADJ_TAB[k][j][1]];
				neg = (adj < 0) != (det < 0);
				q   = $unsigned(wabs(adj) <<< (2 * FB)) / $unsigned(wabs(det));
				lim = neg ? (wide_t'(1) <<< (EW - 1)) : (wide_t'(1) <<< (EW - 1)) - 1;
				if ($unsigned(q) > $unsigned(lim)) q = lim;
				if (neg) q = -q;
				b.value = q[EW-1:0];
			end
			inverse_q.push_back(b);
		end
	endfunction

	// Expectations read straight off the matrix for the zero and identity cases.
	function automatic void push_known(input int kind);
		inv_beat_t b;
		for (int k = 0; k < 16; k++) begin
			b.index = 4'(k);
			b.last  = (k == 15);
			b.sing  = (kind == MK_ZERO);
			b.value = (kind == MK_IDENT && (k % 5 == 0)) ? ONE_Q : '0;
			inverse_q.push_back(b);
		end
	endfunction

	function automatic logic [EW-1:0] pick_elem(input int style);
		logic [EW-1:0] v;
		case (style)
			0: v = EW'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			1: v = $urandom;
			2: v = EW'($urandom_range(0, 6)) - 32'd3;
			default: begin
				case ($urandom_range(0, 4))
					0: v = MIN_E;
					1: v = MAX_E;
					2: v = '0;
					3: v = '1;
					default: v = EW'($urandom_range(1, 3));
				endcase
			end
		endcase
		return v;
	endfunction

	// Random matrices: most often well-conditioned small values, some full-range,
	// some tiny raw integers (near-singular, saturating), some extremes, and
	// some made singular by copying a row.
	task automatic build_random();
		logic [EW-1:0] mat [16];
		int            style;
		int            shape;
		int            src;
		for (int n = 0; n < 24; n++) begin
			shape = $urandom_range(0, 9);
			case (shape)
				0, 1, 2, 3: style = 0;
				4, 5:       style = 1;
				6, 7:       style = 2;
				default:    style = 3;
			endcase
			for (int k = 0; k < 16; k++) mat[k] = pick_elem(style);
			if (shape == 3 || shape == 6) begin
				src = 4 * $urandom_range(0, 2);
				for (int c = 0; c < 4; c++) mat[12 + c] = mat[src + c];
			end
			for (int k = 0; k < 16; k++) stim_q.push_back('{mat[k], MK_MODEL});
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		element_valid = 1'b0;
		element_value = '0;
		result_ready  = 1'b0;
		load_pos      = 0;
		sent          = 0;
		send_gap      = 0;
		recv_gap      = 0;
		mismatches    = 0;
		stim_done     = 1'b0;
		foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
		build_random();
		quiet_from = stim_q.size() - stim_q.size() / 8;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Element driver: one beat per handshake, random idle bursts except near the end.
	always @(posedge clk) begin
		if (arst_n) begin
			if (element_valid && element_ready) begin
				matrix_buf[load_pos] = element_value;
				if (load_pos == 15) begin
					if (stim_q[sent - 1].kind == MK_MODEL) predict_inverse();
					else push_known(stim_q[sent - 1].kind);
					load_pos = 0;
				end else begin
					load_pos = load_pos + 1;
				end
			end
			if (!element_valid || element_ready) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
					element_valid <= 1'b0;
				end else if (sent < stim_q.size()) begin
					element_valid <= 1'b1;
					element_value <= stim_q[sent].value;
					sent = sent + 1;
					if (sent < quiet_from && $urandom_range(0, 3) == 0)
						send_gap = $urandom_range(1, 3);
				end else begin
					element_valid <= 1'b0;
					stim_done = 1'b1;
				end
			end
		end
	end

	// Result receiver: random stall bursts, none in the last part of the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (recv_gap > 0) begin
				recv_gap = recv_gap - 1;
				result_ready <= 1'b0;
			end else if (sent < quiet_from && $urandom_range(0, 3) == 0) begin
				recv_gap = $urandom_range(0, 2);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Result checker: each accepted beat against the oldest expected beat.
	always @(posedge clk) begin
		inv_beat_t e;
		if (arst_n && result_valid && result_ready) begin
			if (inverse_q.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result beat: value %h index %0d", result_value,
						result_index);
			end else begin
				e = inverse_q.pop_front();
				if (result_value !== e.value || result_index !== e.index
					|| singular !== e.sing || last !== e.last) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("result mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
							e.value, e.index, e.sing, e.last,
							result_value, result_index, singular, last);
				end
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		wait (stim_done);
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && inverse_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
